FILE: rtl/pma_pkg.sv
// Package for the prime field arithmetic unit: widths, reset constants,
// microcode word types, the control store and the action dispatch table.
// No dependencies.
`default_nettype none

package pma_pkg;

    localparam int RESIDUE_BITS_DEF = 20;
    localparam longint unsigned MODULUS_RESET = 64'd1000003;
    localparam int ACTION_W = 3;
    localparam int WIDE_W = 64;
    localparam int CNT_W = 7;
    localparam int PC_W = 6;

    localparam logic [ACTION_W-1:0] ACT_REDUCE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUB    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MUL    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DIV    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_POW    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_NEG    = 3'd6;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_RED_A,
        OP_RED_B,
        OP_RED_RAW,
        OP_RED_PROD,
        OP_MUL_AB,
        OP_MUL_AACC,
        OP_MUL_ACCBASE,
        OP_MUL_BASESQ,
        OP_WR_A,
        OP_WR_B,
        OP_WR_ACC,
        OP_WR_BASE_SHR,
        OP_WR_RES,
        OP_RES_ADD,
        OP_RES_SUB,
        OP_RES_NEG,
        OP_RES_NEGRAW,
        OP_RES_ZERO,
        OP_RES_ACC,
        OP_INIT_B_INV,
        OP_INIT_A_INV,
        OP_INIT_A_EXP,
        OP_INIT_ACC_EXP,
        OP_DONE
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_P_LT2,
        C_DISPATCH,
        C_EXP_ZERO,
        C_EXP_EVEN,
        C_EX_NONNEG
    } ucond_t;

    typedef struct packed {
        uop_t             op;
        ucond_t           cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] value;
        logic [CNT_W-1:0]  nbits;
    } rem_ctrl_t;

    // program entry points and loop labels
    localparam logic [PC_W-1:0] PC_START        = 6'd0;
    localparam logic [PC_W-1:0] PC_REDUCE       = 6'd5;
    localparam logic [PC_W-1:0] PC_ADD          = 6'd8;
    localparam logic [PC_W-1:0] PC_SUB          = 6'd9;
    localparam logic [PC_W-1:0] PC_NEG          = 6'd10;
    localparam logic [PC_W-1:0] PC_MUL          = 6'd11;
    localparam logic [PC_W-1:0] PC_DIV          = 6'd14;
    localparam logic [PC_W-1:0] PC_DIV_LOOP     = 6'd15;
    localparam logic [PC_W-1:0] PC_DIV_SQ       = 6'd20;
    localparam logic [PC_W-1:0] PC_DIV_END      = 6'd23;
    localparam logic [PC_W-1:0] PC_POW          = 6'd26;
    localparam logic [PC_W-1:0] PC_INV_LOOP     = 6'd28;
    localparam logic [PC_W-1:0] PC_INV_SQ       = 6'd33;
    localparam logic [PC_W-1:0] PC_INV_END      = 6'd36;
    localparam logic [PC_W-1:0] PC_POW_POS      = 6'd37;
    localparam logic [PC_W-1:0] PC_POW_LOOP     = 6'd38;
    localparam logic [PC_W-1:0] PC_POW_SQ       = 6'd43;
    localparam logic [PC_W-1:0] PC_POW_END      = 6'd46;
    localparam logic [PC_W-1:0] PC_ZERO         = 6'd47;
    localparam logic [PC_W-1:0] PC_DONE         = 6'd48;

    function automatic uword_t mk(input uop_t op, input ucond_t cond,
                                  input logic [PC_W-1:0] target);
        uword_t w;
        w.op = op;
        w.cond = cond;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        case (addr)
            // prologue: zero result if p < 2, else reduce both operands, then dispatch
            6'd0:  w = mk(OP_NOP,          C_P_LT2,     PC_ZERO);
            6'd1:  w = mk(OP_RED_A,        C_NEXT,      PC_START);
            6'd2:  w = mk(OP_WR_A,         C_NEXT,      PC_START);
            6'd3:  w = mk(OP_RED_B,        C_NEXT,      PC_START);
            6'd4:  w = mk(OP_WR_B,         C_DISPATCH,  PC_START);
            // reduce
            6'd5:  w = mk(OP_RED_RAW,      C_NEXT,      PC_START);
            6'd6:  w = mk(OP_WR_RES,       C_NEXT,      PC_START);
            6'd7:  w = mk(OP_RES_NEGRAW,   C_JUMP,      PC_DONE);
            // add, sub, negate
            6'd8:  w = mk(OP_RES_ADD,      C_JUMP,      PC_DONE);
            6'd9:  w = mk(OP_RES_SUB,      C_JUMP,      PC_DONE);
            6'd10: w = mk(OP_RES_NEG,      C_JUMP,      PC_DONE);
            // mul
            6'd11: w = mk(OP_MUL_AB,       C_NEXT,      PC_START);
            6'd12: w = mk(OP_RED_PROD,     C_NEXT,      PC_START);
            6'd13: w = mk(OP_WR_RES,       C_JUMP,      PC_DONE);
            // div: acc = b^(p-2), then a * acc
            6'd14: w = mk(OP_INIT_B_INV,   C_NEXT,      PC_START);
            6'd15: w = mk(OP_NOP,          C_EXP_ZERO,  PC_DIV_END);
            6'd16: w = mk(OP_NOP,          C_EXP_EVEN,  PC_DIV_SQ);
            6'd17: w = mk(OP_MUL_ACCBASE,  C_NEXT,      PC_START);
            6'd18: w = mk(OP_RED_PROD,     C_NEXT,      PC_START);
            6'd19: w = mk(OP_WR_ACC,       C_NEXT,      PC_START);
            6'd20: w = mk(OP_MUL_BASESQ,   C_NEXT,      PC_START);
            6'd21: w = mk(OP_RED_PROD,     C_NEXT,      PC_START);
            6'd22: w = mk(OP_WR_BASE_SHR,  C_JUMP,      PC_DIV_LOOP);
            6'd23: w = mk(OP_MUL_AACC,     C_NEXT,      PC_START);
            6'd24: w = mk(OP_RED_PROD,     C_NEXT,      PC_START);
            6'd25: w = mk(OP_WR_RES,       C_JUMP,      PC_DONE);
            // pow, negative exponent: invert base first
            6'd26: w = mk(OP_NOP,          C_EX_NONNEG, PC_POW_POS);
            6'd27: w = mk(OP_INIT_A_INV,   C_NEXT,      PC_START);
            6'd28: w = mk(OP_NOP,          C_EXP_ZERO,  PC_INV_END);
            6'd29: w = mk(OP_NOP,          C_EXP_EVEN,  PC_INV_SQ);
            6'd30: w = mk(OP_MUL_ACCBASE,  C_NEXT,      PC_START);
            6'd31: w = mk(OP_RED_PROD,     C_NEXT,      PC_START);
            6'd32: w = mk(OP_WR_ACC,       C_NEXT,      PC_START);
            6'd33: w = mk(OP_MUL_BASESQ,   C_NEXT,      PC_START);
            6'd34: w = mk(OP_RED_PROD,     C_NEXT,      PC_START);
            6'd35: w = mk(OP_WR_BASE_SHR,  C_JUMP,      PC_INV_LOOP);
            6'd36: w = mk(OP_INIT_ACC_EXP, C_JUMP,      PC_POW_LOOP);
            6'd37: w = mk(OP_INIT_A_EXP,   C_NEXT,      PC_START);
            // square and multiply over the exponent magnitude
            6'd38: w = mk(OP_NOP,          C_EXP_ZERO,  PC_POW_END);
            6'd39: w = mk(OP_NOP,          C_EXP_EVEN,  PC_POW_SQ);
            6'd40: w = mk(OP_MUL_ACCBASE,  C_NEXT,      PC_START);
            6'd41: w = mk(OP_RED_PROD,     C_NEXT,      PC_START);
            6'd42: w = mk(OP_WR_ACC,       C_NEXT,      PC_START);
            6'd43: w = mk(OP_MUL_BASESQ,   C_NEXT,      PC_START);
            6'd44: w = mk(OP_RED_PROD,     C_NEXT,      PC_START);
            6'd45: w = mk(OP_WR_BASE_SHR,  C_JUMP,      PC_POW_LOOP);
            6'd46: w = mk(OP_RES_ACC,      C_JUMP,      PC_DONE);
            // zero result, then deliver
            6'd47: w = mk(OP_RES_ZERO,     C_NEXT,      PC_START);
            6'd48: w = mk(OP_DONE,         C_NEXT,      PC_START);
            default: w = mk(OP_DONE,       C_NEXT,      PC_START);
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] action_entry(input logic [ACTION_W-1:0] act);
        logic [PC_W-1:0] pc;
        case (act)
            ACT_REDUCE: pc = PC_REDUCE;
            ACT_ADD:    pc = PC_ADD;
            ACT_SUB:    pc = PC_SUB;
            ACT_MUL:    pc = PC_MUL;
            ACT_DIV:    pc = PC_DIV;
            ACT_POW:    pc = PC_POW;
            ACT_NEG:    pc = PC_NEG;
            default:    pc = PC_ZERO;
        endcase
        return pc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/prime_modular_alu.sv
// Top level of the prime field arithmetic unit: stream ports, modulus
// register, microcoded sequencer and datapath. Uses pma_pkg, pma_rem_unit.
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tdata: action, operand_a, operand_b,
//                                              exponent, raw_value
//  m_        out  m_tvalid/m_tready   m_tdata: result, operands_equal
//  cfg_      in   cfg_wr_en           cfg_wr_data: modulus
//
// One item at a time; every reduction runs on the shared bit-serial remainder
// unit, one bit per cycle (W = RESIDUE_BITS). Operands are reduced first; then
// add/sub/negate, reduce or mul runs. Each exponent bit takes a multiply and a
// square when set and a square alone when clear, over the bits of p-2 for div
// and |exponent| for pow (of p-2 first too when the exponent is negative).
// Synchronous active-low reset clears control and loads modulus 1000003.
// A finished item waits in the output register while the next one is taken.
`default_nettype none

module prime_modular_alu #(
    parameter int RESIDUE_BITS = pma_pkg::RESIDUE_BITS_DEF,
    localparam int S_TDATA_W = ((pma_pkg::ACTION_W + 2*RESIDUE_BITS
                                 + 2*pma_pkg::WIDE_W + 7) / 8) * 8,
    localparam int M_TDATA_W = ((RESIDUE_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [RESIDUE_BITS-1:0] cfg_wr_data,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // action, operand_a, operand_b, exponent, raw_value
    input  wire logic [S_TDATA_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // result, operands_equal
    output logic [M_TDATA_W-1:0]         m_tdata
);
    import pma_pkg::*;

    localparam int W = RESIDUE_BITS;
    localparam int OFS_A = ACTION_W;
    localparam int OFS_B = OFS_A + W;
    localparam int OFS_EX = OFS_B + W;
    localparam int OFS_RAW = OFS_EX + WIDE_W;

    logic [W-1:0]        modulus_reg;
    logic                busy_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [PC_W-1:0]     pc_next;
    logic [ACTION_W-1:0] action_reg;
    logic [W-1:0]        a_reg;
    logic [W-1:0]        b_reg;
    logic [WIDE_W-1:0]   ex_reg;
    logic [WIDE_W-1:0]   raw_reg;
    logic                eq_reg;
    logic [W-1:0]        acc_reg;
    logic [W-1:0]        base_reg;
    logic [WIDE_W-1:0]   exp_reg;
    logic [2*W-1:0]      prod_reg;
    logic [W-1:0]        res_reg;
    logic                m_valid_reg;
    logic [W-1:0]        m_result_reg;
    logic                m_equal_reg;

    uword_t              uw;
    logic                step_done;
    logic                cond_true;
    logic                accept;
    rem_ctrl_t           rctl;
    logic                rem_busy;
    logic [W-1:0]        rem;
    logic [W-1:0]        mul_x;
    logic [W-1:0]        mul_y;
    logic [W:0]          sum_ab;
    logic [W:0]          sub_ab;
    logic [WIDE_W-1:0]   raw_mag;
    logic [WIDE_W-1:0]   ex_mag;

    pma_rem_unit #(
        .RESIDUE_BITS(RESIDUE_BITS)
    ) u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rctl),
        .modulus (modulus_reg),
        .busy    (rem_busy),
        .rem     (rem)
    );

    assign accept = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = M_TDATA_W'({m_equal_reg, m_result_reg});

    assign raw_mag = raw_reg[WIDE_W-1] ? (WIDE_W'(0) - raw_reg) : raw_reg;
    assign ex_mag = ex_reg[WIDE_W-1] ? (WIDE_W'(0) - ex_reg) : ex_reg;
    assign sum_ab = {1'b0, a_reg} + {1'b0, b_reg};
    assign sub_ab = {1'b0, a_reg} + {1'b0, modulus_reg} - {1'b0, b_reg};

    always_comb begin
        uw = ucode_rom(pc_reg);

        case (uw.op)
            OP_WR_A, OP_WR_B, OP_WR_ACC, OP_WR_BASE_SHR, OP_WR_RES: step_done = !rem_busy;
            OP_DONE: step_done = !m_valid_reg || m_tready;
            default: step_done = 1'b1;
        endcase

        case (uw.cond)
            C_JUMP:      cond_true = 1'b1;
            C_P_LT2:     cond_true = (modulus_reg < W'(2));
            C_DISPATCH:  cond_true = 1'b1;
            C_EXP_ZERO:  cond_true = (exp_reg == '0);
            C_EXP_EVEN:  cond_true = !exp_reg[0];
            C_EX_NONNEG: cond_true = !ex_reg[WIDE_W-1];
            default:     cond_true = 1'b0;
        endcase

        if (!step_done) begin
            pc_next = pc_reg;
        end else if (uw.cond == C_DISPATCH) begin
            pc_next = action_entry(action_reg);
        end else if (cond_true) begin
            pc_next = uw.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end

        rctl.start = 1'b0;
        rctl.value = '0;
        rctl.nbits = CNT_W'(W);
        if (busy_reg) begin
            case (uw.op)
                OP_RED_A: begin
                    rctl.start = 1'b1;
                    rctl.value = WIDE_W'(a_reg) << (WIDE_W - W);
                end
                OP_RED_B: begin
                    rctl.start = 1'b1;
                    rctl.value = WIDE_W'(b_reg) << (WIDE_W - W);
                end
                OP_RED_RAW: begin
                    rctl.start = 1'b1;
                    rctl.value = raw_mag;
                    rctl.nbits = CNT_W'(WIDE_W);
                end
                OP_RED_PROD: begin
                    rctl.start = 1'b1;
                    rctl.value = WIDE_W'(prod_reg) << (WIDE_W - 2*W);
                    rctl.nbits = CNT_W'(2*W);
                end
                default: ;
            endcase
        end

        case (uw.op)
            OP_MUL_AB: begin
                mul_x = a_reg;
                mul_y = b_reg;
            end
            OP_MUL_AACC: begin
                mul_x = a_reg;
                mul_y = acc_reg;
            end
            OP_MUL_ACCBASE: begin
                mul_x = acc_reg;
                mul_y = base_reg;
            end
            default: begin
                mul_x = base_reg;
                mul_y = base_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= W'(MODULUS_RESET);
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= PC_START;
            m_valid_reg <= 1'b0;
        end else begin
            // the output step reloads the register in the same cycle it drains
            if (m_valid_reg && m_tready && !(busy_reg && (uw.op == OP_DONE))) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                busy_reg   <= 1'b1;
                pc_reg     <= PC_START;
                action_reg <= s_tdata[ACTION_W-1:0];
                a_reg      <= s_tdata[OFS_A +: W];
                b_reg      <= s_tdata[OFS_B +: W];
                ex_reg     <= s_tdata[OFS_EX +: WIDE_W];
                raw_reg    <= s_tdata[OFS_RAW +: WIDE_W];
                eq_reg     <= (s_tdata[OFS_A +: W] == s_tdata[OFS_B +: W]);
            end else if (busy_reg) begin
                pc_reg <= pc_next;
                case (uw.op)
                    OP_MUL_AB, OP_MUL_AACC, OP_MUL_ACCBASE, OP_MUL_BASESQ: begin
                        prod_reg <= {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
                    end
                    OP_WR_A: if (step_done) a_reg <= rem;
                    OP_WR_B: if (step_done) b_reg <= rem;
                    OP_WR_ACC: if (step_done) acc_reg <= rem;
                    OP_WR_RES: if (step_done) res_reg <= rem;
                    OP_WR_BASE_SHR: begin
                        if (step_done) begin
                            base_reg <= rem;
                            exp_reg  <= exp_reg >> 1;
                        end
                    end
                    OP_RES_ADD: begin
                        res_reg <= (sum_ab >= {1'b0, modulus_reg})
                                   ? W'(sum_ab - {1'b0, modulus_reg}) : sum_ab[W-1:0];
                    end
                    OP_RES_SUB: begin
                        res_reg <= (a_reg >= b_reg) ? (a_reg - b_reg) : sub_ab[W-1:0];
                    end
                    OP_RES_NEG: begin
                        res_reg <= (a_reg != '0) ? (modulus_reg - a_reg) : '0;
                    end
                    OP_RES_NEGRAW: begin
                        if (raw_reg[WIDE_W-1] && (res_reg != '0)) begin
                            res_reg <= modulus_reg - res_reg;
                        end
                    end
                    OP_RES_ZERO: res_reg <= '0;
                    OP_RES_ACC: res_reg <= acc_reg;
                    OP_INIT_B_INV: begin
                        base_reg <= b_reg;
                        exp_reg  <= WIDE_W'(modulus_reg - W'(2));
                        acc_reg  <= W'(1);
                    end
                    OP_INIT_A_INV: begin
                        base_reg <= a_reg;
                        exp_reg  <= WIDE_W'(modulus_reg - W'(2));
                        acc_reg  <= W'(1);
                    end
                    OP_INIT_A_EXP: begin
                        base_reg <= a_reg;
                        exp_reg  <= ex_mag;
                        acc_reg  <= W'(1);
                    end
                    OP_INIT_ACC_EXP: begin
                        base_reg <= acc_reg;
                        exp_reg  <= ex_mag;
                        acc_reg  <= W'(1);
                    end
                    OP_DONE: begin
                        if (step_done) begin
                            m_valid_reg  <= 1'b1;
                            m_result_reg <= res_reg;
                            m_equal_reg  <= eq_reg;
                            busy_reg     <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pma_rem_unit.sv
// Bit-serial remainder unit: shifts a value in MSB first, one bit a cycle,
// keeping rem < modulus with one compare and subtract. Uses pma_pkg.
`default_nettype none

module pma_rem_unit #(
    parameter int RESIDUE_BITS = pma_pkg::RESIDUE_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire pma_pkg::rem_ctrl_t      ctrl,
    input  wire logic [RESIDUE_BITS-1:0] modulus,
    output logic                         busy,
    output logic [RESIDUE_BITS-1:0]      rem
);
    import pma_pkg::*;

    logic [WIDE_W-1:0]       sreg_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic [RESIDUE_BITS-1:0] rem_reg;
    logic [RESIDUE_BITS-1:0] rem_next;
    logic [RESIDUE_BITS:0]   shifted;
    logic [RESIDUE_BITS:0]   diff;

    always_comb begin
        shifted = {rem_reg, sreg_reg[WIDE_W-1]};
        diff = shifted - {1'b0, modulus};
        rem_next = (shifted >= {1'b0, modulus}) ? diff[RESIDUE_BITS-1:0]
                                                : shifted[RESIDUE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (ctrl.start) begin
            sreg_reg <= ctrl.value;
            cnt_reg  <= ctrl.nbits;
            rem_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            sreg_reg <= {sreg_reg[WIDE_W-2:0], 1'b0};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign rem = rem_reg;

endmodule

`default_nettype wire
